// ===== rtl/core/assert_macros.svh =====
// Assertion macros of the linked list core.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/core/dll_pkg.sv =====
// Package of the linked list core: command and result codes, sizes.
// Depends on nothing; used by every module of the core.
package dll_pkg;
  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS = 32;
  localparam int ID_W = 16;
  localparam int TAG_W = 64;

  localparam logic [2:0] FUNC_ADD_FRONT = 3'd0;
  localparam logic [2:0] FUNC_ADD_END = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_NEXT = 3'd3;
  localparam logic [2:0] FUNC_PREV = 3'd4;
  localparam logic [2:0] FUNC_LIST_FWD = 3'd5;
  localparam logic [2:0] FUNC_LIST_BWD = 3'd6;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic       last;
  } res_ctl_t;
endpackage

// ===== rtl/core/dll_alloc.sv =====
// Slot usage flags and lowest-free-slot search of the linked list core.
// Depends on dll_pkg.
module dll_alloc #(
  parameter int CAPACITY = dll_pkg::CAPACITY_DEF,
  parameter int PW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          set_en,
  input  logic          clr_en,
  input  logic [PW-1:0] slot,
  output logic          full,
  output logic [PW-1:0] free_slot
);
  logic [CAPACITY-1:0] used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (set_en) used_r[slot[$clog2(CAPACITY)-1:0]] <= 1'b1;
      if (clr_en) used_r[slot[$clog2(CAPACITY)-1:0]] <= 1'b0;
    end
  end

  // Priority encoder over the free flags.
  always_comb begin
    free_slot = PW'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) free_slot = PW'(i);
    end
  end
  assign full = &used_r;
endmodule

// ===== rtl/core/doubly_linked_list_with_cursor_core.sv =====
// Top level of the linked list core: sequencer, node memories, pointers.
// Depends on dll_pkg, dll_alloc and assert_macros.svh.
//
//  channel | ports                              | direction
//  in      | start, busy, in_func/id/tag        | command beat in
//  out     | out_valid, out_kind/id/tag/last    | result beat out, no stall
//
// A command is taken when start is high and busy is low. Busy then stays high
// until the command is done: an add takes a free slot and links the node at
// the front or end, or reports full on a full pool; a move reads the cursor
// node, if any, and then its neighbour; a delete reads and compares nodes from
// the head until an id matches or the list ends; a listing reads one node per
// result reported. The node memories have a single read port. Reset (rst_n low
// at a clock edge) empties the list at once. Results are shown one cycle each and cannot be held off.
`include "assert_macros.svh"
module doubly_linked_list_with_cursor_core #(
  parameter int CAPACITY = dll_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_func,
  input  logic [dll_pkg::ID_W-1:0] in_entry_id,
  input  logic [dll_pkg::TAG_W-1:0] in_entry_tag,
  output logic                     out_valid,
  output logic [1:0]               out_kind,
  output logic [dll_pkg::ID_W-1:0] out_out_id,
  output logic [dll_pkg::TAG_W-1:0] out_out_tag,
  output logic                     out_last
);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);
  localparam int CW = $clog2(CAPACITY + dll_pkg::MAX_RESULTS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD = 4'd1;
  localparam logic [3:0] S_ADD_LINK = 4'd2;
  localparam logic [3:0] S_RD = 4'd3;
  localparam logic [3:0] S_DEL_CHK = 4'd4;
  localparam logic [3:0] S_DEL_P = 4'd5;
  localparam logic [3:0] S_DEL_N = 4'd6;
  localparam logic [3:0] S_MOV_CHK = 4'd7;
  localparam logic [3:0] S_MOV_CHK2 = 4'd8;
  localparam logic [3:0] S_LIST = 4'd9;

  // Node memories, one read port (registered) and one write port per array.
  logic [dll_pkg::ID_W-1:0]  ids_mem [CAPACITY];
  logic [dll_pkg::TAG_W-1:0] tags_mem [CAPACITY];
  logic [PW-1:0]             prev_mem [CAPACITY];
  logic [PW-1:0]             next_mem [CAPACITY];

  logic [dll_pkg::ID_W-1:0]  rd_id_r;
  logic [dll_pkg::TAG_W-1:0] rd_tag_r;
  logic [PW-1:0]             rd_prev_r, rd_next_r;

  logic [3:0]  state_r, state_nxt;
  logic [2:0]  func_r;
  logic [dll_pkg::ID_W-1:0]  id_r;
  logic [dll_pkg::TAG_W-1:0] tag_r;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt, slot_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          walk_fwd_r;

  // Memory controls.
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          wn_en, wp_en, wd_en;
  logic [PW-1:0] wn_addr, wn_data, wp_addr, wp_data;

  dll_pkg::res_ctl_t res_nxt, res_r;
  logic [dll_pkg::ID_W-1:0]  res_id_r;
  logic [dll_pkg::TAG_W-1:0] res_tag_r;
  logic                      res_entry;

  logic          al_set, al_clr, al_full;
  logic [PW-1:0] al_slot, al_free;

  dll_alloc #(.CAPACITY(CAPACITY), .PW(PW)) u_alloc (
    .clk(clk), .rst_n(rst_n), .set_en(al_set), .clr_en(al_clr),
    .slot(al_slot), .full(al_full), .free_slot(al_free)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id_r   <= ids_mem[rd_addr[AW-1:0]];
      rd_tag_r  <= tags_mem[rd_addr[AW-1:0]];
      rd_prev_r <= prev_mem[rd_addr[AW-1:0]];
      rd_next_r <= next_mem[rd_addr[AW-1:0]];
    end
    if (wd_en) begin
      ids_mem[slot_r[AW-1:0]]  <= id_r;
      tags_mem[slot_r[AW-1:0]] <= tag_r;
    end
    if (wn_en) next_mem[wn_addr[AW-1:0]] <= wn_data;
    if (wp_en) prev_mem[wp_addr[AW-1:0]] <= wp_data;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cur_nxt = cur_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    rd_en = 1'b0;
    rd_addr = ptr_r;
    wn_en = 1'b0; wn_addr = slot_r; wn_data = NIL;
    wp_en = 1'b0; wp_addr = slot_r; wp_data = NIL;
    wd_en = 1'b0;
    al_set = 1'b0; al_clr = 1'b0; al_slot = slot_r;
    res_nxt = '0;
    res_entry = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_func)
            dll_pkg::FUNC_ADD_FRONT, dll_pkg::FUNC_ADD_END: state_nxt = S_ADD;
            dll_pkg::FUNC_DELETE: begin
              ptr_nxt = head_r;
              cnt_nxt = '0;
              state_nxt = S_RD;
            end
            dll_pkg::FUNC_NEXT, dll_pkg::FUNC_PREV: begin
              ptr_nxt = cur_r;
              cnt_nxt = '0;
              state_nxt = S_RD;
            end
            dll_pkg::FUNC_LIST_FWD: begin
              ptr_nxt = head_r; cnt_nxt = '0; state_nxt = S_RD;
            end
            dll_pkg::FUNC_LIST_BWD: begin
              ptr_nxt = tail_r; cnt_nxt = '0; state_nxt = S_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (al_full) begin
          res_nxt = '{vld: 1'b1, kind: dll_pkg::KIND_FULL, last: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          al_set = 1'b1; al_slot = al_free;
          state_nxt = S_ADD_LINK;
        end
      end
      S_ADD_LINK: begin
        wd_en = 1'b1;
        wn_en = 1'b1; wp_en = 1'b1;
        if (head_r == NIL || tail_r == NIL) begin
          head_nxt = slot_r; tail_nxt = slot_r; cur_nxt = slot_r;
          state_nxt = S_IDLE;
        end else if (func_r == dll_pkg::FUNC_ADD_FRONT) begin
          wn_data = head_r;
          head_nxt = slot_r;
          ptr_nxt = head_r;
          state_nxt = S_DEL_P;
        end else begin
          wp_data = tail_r;
          tail_nxt = slot_r;
          ptr_nxt = tail_r;
          state_nxt = S_DEL_N;
        end
      end
      S_RD: begin
        // Uniform node read step for all walkers; a null pointer or a full count ends the walk.
        if (ptr_r == NIL || cnt_r == CW'(CAPACITY)) begin
          if (func_r == dll_pkg::FUNC_NEXT) begin
            res_nxt = '{vld: 1'b1, kind: dll_pkg::KIND_END, last: 1'b1};
          end else if (func_r == dll_pkg::FUNC_PREV) begin
            res_nxt = '{vld: 1'b1, kind: dll_pkg::KIND_START, last: 1'b1};
          end
          state_nxt = S_IDLE;
        end else begin
          rd_en = 1'b1;
          priority if (func_r == dll_pkg::FUNC_DELETE) state_nxt = S_DEL_CHK;
          else if (func_r == dll_pkg::FUNC_NEXT || func_r == dll_pkg::FUNC_PREV)
            state_nxt = S_MOV_CHK;
          else state_nxt = S_LIST;
        end
      end
      S_DEL_CHK: begin
        if (rd_id_r == id_r) begin
          if (ptr_r == head_r) head_nxt = rd_next_r;
          if (ptr_r == tail_r) tail_nxt = rd_prev_r;
          if (cur_r == ptr_r) cur_nxt = (rd_next_r != NIL) ? rd_next_r : rd_prev_r;
          al_clr = 1'b1; al_slot = ptr_r;
          wn_en = (rd_prev_r != NIL); wn_addr = rd_prev_r; wn_data = rd_next_r;
          wp_en = (rd_next_r != NIL); wp_addr = rd_next_r; wp_data = rd_prev_r;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = rd_next_r;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DEL_P: begin
        // Link old head back to the new front node.
        wp_en = 1'b1; wp_addr = ptr_r; wp_data = slot_r;
        state_nxt = S_IDLE;
      end
      S_DEL_N: begin
        wn_en = 1'b1; wn_addr = ptr_r; wn_data = slot_r;
        state_nxt = S_IDLE;
      end
      S_MOV_CHK: begin
        ptr_nxt = walk_fwd_r ? rd_next_r : rd_prev_r;
        if (ptr_nxt == NIL) begin
          res_nxt = '{vld: 1'b1, kind: walk_fwd_r ? dll_pkg::KIND_END
                                                  : dll_pkg::KIND_START, last: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = ptr_nxt;
          rd_en = 1'b1; rd_addr = ptr_nxt;
          state_nxt = S_MOV_CHK2;
        end
      end
      S_MOV_CHK2: begin
        if ((walk_fwd_r ? rd_next_r : rd_prev_r) == NIL) begin
          res_nxt = '{vld: 1'b1, kind: walk_fwd_r ? dll_pkg::KIND_END
                                                  : dll_pkg::KIND_START, last: 1'b1};
        end
        state_nxt = S_IDLE;
      end
      S_LIST: begin
        ptr_nxt = walk_fwd_r ? rd_next_r : rd_prev_r;
        cnt_nxt = cnt_r + 1'b1;
        res_entry = 1'b1;
        res_nxt.vld = 1'b1;
        res_nxt.kind = dll_pkg::KIND_ENTRY;
        res_nxt.last = (ptr_nxt == NIL) || (cnt_nxt == CW'(CAPACITY)) ||
                       (cnt_nxt == CW'(dll_pkg::MAX_RESULTS));
        state_nxt = res_nxt.last ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= NIL;
      tail_r <= NIL;
      cur_r <= NIL;
      res_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cur_r <= cur_nxt;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == S_ADD) slot_r <= al_free;
    if (state_r == S_IDLE && start) begin
      func_r <= in_func;
      id_r <= in_entry_id;
      tag_r <= in_entry_tag;
      walk_fwd_r <= (in_func == dll_pkg::FUNC_NEXT) ||
                    (in_func == dll_pkg::FUNC_LIST_FWD);
    end
    res_id_r <= res_entry ? rd_id_r : '0;
    res_tag_r <= res_entry ? rd_tag_r : '0;
  end

  assign out_valid = res_r.vld;
  assign out_kind = res_r.kind;
  assign out_last = res_r.last;
  assign out_out_id = res_id_r;
  assign out_out_tag = res_tag_r;

  // After a result that is not the last one, the core is still busy.
  `ASSERT_NEXT(a_res_busy, clk, rst_n, res_nxt.vld && !res_nxt.last, busy)
  // While idle, head and tail are null together.
  `ASSERT_IMPLIES(a_ends, clk, rst_n, state_r == S_IDLE, (head_r == NIL) == (tail_r == NIL))
  // An empty list has no cursor.
  `ASSERT_IMPLIES(a_cur, clk, rst_n, state_r == S_IDLE && head_r == NIL, cur_r == NIL)
endmodule
